// File: rtl/core/range_linearize_filter_pi_steer_top_assert.svh
// Assertion macros shared by the steering block.
`ifndef RANGE_LINEARIZE_FILTER_PI_STEER_TOP_ASSERT_SVH
`define RANGE_LINEARIZE_FILTER_PI_STEER_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RLF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RLF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/rlf_pkg.sv
package rlf_pkg;

  localparam int unsigned FracBits = 8;
  localparam logic [19:0] DistMax  = 20'hFFFFF;

  // Breakpoint given in hundredths, rounded to FracBits fraction bits.
  function automatic logic [16:0] bp_of(input longint c);
    return 17'(((c << FracBits) + 50) / 100);
  endfunction

  // Segment offset given in millionths, rounded to FracBits+16 fraction bits.
  function automatic logic signed [29:0] ofs_of(input longint c);
    return 30'(((c << (FracBits + 16)) + 500000) / 1000000);
  endfunction

  // Breakpoints in distance units.
  localparam logic [16:0] Bp184  = bp_of(184);
  localparam logic [16:0] Bp828  = bp_of(828);
  localparam logic [16:0] Bp1017 = bp_of(1017);
  localparam logic [16:0] Bp1694 = bp_of(1694);
  localparam logic [16:0] Bp1825 = bp_of(1825);
  localparam logic [16:0] Bp2495 = bp_of(2495);
  localparam logic [16:0] Bp2631 = bp_of(2631);
  localparam logic [16:0] Bp3125 = bp_of(3125);

  // Segment slopes (Q.16) and offsets (FracBits+16 fraction bits).
  localparam logic [17:0] Slp0 = 18'd87691;
  localparam logic [17:0] Slp1 = 18'd76366;
  localparam logic [17:0] Slp2 = 18'd82214;
  localparam logic [17:0] Slp3 = 18'd82612;
  localparam logic signed [29:0] Ofs0 = -ofs_of(682216);
  localparam logic signed [29:0] Ofs1 = ofs_of(203794);
  localparam logic signed [29:0] Ofs2 = -ofs_of(1053040);
  localparam logic signed [29:0] Ofs3 = -ofs_of(1409490);

  localparam logic signed [23:0] SteerMax = 24'sh7FFFFF;
  localparam logic signed [23:0] SteerMin = -24'sh800000;

  // Dead band limits of the steering value and the stand-in for a missing side wall.
  localparam logic signed [23:0] SteerOne   = 24'(1 << FracBits);
  localparam logic signed [23:0] SteerOne75 = 24'(7 << (FracBits - 2));
  localparam logic signed [21:0] NoWallDist = 22'(7 << (FracBits - 1));

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0, CMD_FORWARD = 3'd1, CMD_RIGHT_TURN = 3'd2, CMD_LEFT_TURN = 3'd3,
    CMD_RIGHT_STRAFE = 3'd4, CMD_LEFT_STRAFE = 3'd5, CMD_REVERSE = 3'd6
  } motion_cmd_e;

  typedef enum logic [2:0] {
    REG_PROP_GAIN = 3'd0, REG_INTEGRAL_GAIN = 3'd1, REG_CENTRE_OFFSET = 3'd2,
    REG_SIDE_WALL_LIMIT = 3'd3, REG_FILTER_NEW_WEIGHT = 3'd4,
    REG_FILTER_OLD_WEIGHT = 3'd5, REG_FRONT_CLEAR_DISTANCE = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LIN_A, ST_LIN_B, ST_LIN_R, ST_FLT_A, ST_FLT_B, ST_FLT_R,
    ST_ERR, ST_PI_A, ST_PI_B, ST_PI_R, ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic [15:0] raw_front_distance;
    logic [15:0] raw_left_distance;
    logic [15:0] raw_right_distance;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         motion_command;
    logic signed [23:0] steer_value;
    logic [19:0]        front_filtered;
    logic [19:0]        left_filtered;
    logic [19:0]        right_filtered;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        prop_gain;
    logic [15:0]        integral_gain;
    logic signed [15:0] centre_offset;
    logic [15:0]        side_wall_limit;
    logic [15:0]        filter_new_weight;
    logic [15:0]        filter_old_weight;
    logic [15:0]        front_clear_distance;
  } cfg_t;

endpackage

// File: rtl/core/rlf_mac.sv
// Shared multiply-accumulate: acc = (clr ? 0 : acc) + a*b, one product per cycle while enabled.
module rlf_mac import rlf_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               clr_i,
  input  logic signed [32:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [52:0] acc_o
);
  logic signed [52:0] acc_q, acc_d;
  logic signed [50:0] prod;

  assign prod  = a_i * b_i;
  assign acc_d = (clr_i ? 53'sd0 : acc_q) + 53'(prod);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule

// File: rtl/core/range_linearize_filter_pi_steer_top.sv
// Range linearizer, low-pass filter and PI steering unit. Each item carries
// three raw distances in Q8.8 cm. Every channel is linearized with a
// four-segment piecewise-linear map (gaps between segments average the two
// lines, small readings give zero, large readings pass through), then
// low-pass filtered (an empty filter loads the sample). A trapezoidal PI
// controller on the side difference yields a saturated steering value and
// a motion command. All products run through one 33x18 multiply-accumulate
// unit under a sequencer that steps each channel through LIN_A, LIN_B,
// LIN_R, FLT_A, FLT_B and FLT_R, then through ERR, PI_A, PI_B, PI_R and
// OUT. A new item is taken only in idle, after the last result has gone
// into the output register. The result sits in that register, so a stalled
// result holds the sequencer only once the next result is ready for it.
// Configuration writes take effect at once and must be made while idle.
module range_linearize_filter_pi_steer_top import rlf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
`include "range_linearize_filter_pi_steer_top_assert.svh"

  cfg_t cfg_q;
  seq_state_e state_q, state_d;
  logic [1:0] ch_q, ch_d;            // channel being processed
  logic [47:0] raw_q;
  logic [19:0] filt_q [3];
  logic [19:0] lin_q;
  logic signed [31:0] esum_q;
  logic signed [21:0] perr_q;
  logic signed [21:0] err_q;
  logic signed [32:0] sum_q;         // saturated error sum for this item
  logic [2:0] cmd_q;
  logic signed [23:0] steer_q;
  logic out_valid_q;
  out_item_t out_q;

  // The output register is free when empty or being emptied this cycle.
  logic out_free, out_load, out_valid_d;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && out_free;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Segment selection for the current raw value.
  logic [15:0] m;
  logic [1:0]  seg_lo;
  logic        gap, below, above;
  logic [17:0] slp_a, slp_b;
  logic signed [29:0] ofs_a, ofs_b;

  // MAC controls.
  logic mac_en, mac_clr;
  logic signed [32:0] mac_a;
  logic signed [17:0] mac_b;
  logic signed [52:0] acc;

  always_comb begin
    case (ch_q)
      2'd0:    m = raw_q[47:32];
      2'd1:    m = raw_q[31:16];
      default: m = raw_q[15:0];
    endcase
  end

  always_comb begin
    below = m < Bp184;
    above = m > Bp3125;
    gap = 1'b0;
    seg_lo = 2'd0;
    if (m <= Bp828) begin
      seg_lo = 2'd0;
    end else if (m < Bp1017) begin
      seg_lo = 2'd0; gap = 1'b1;
    end else if (m <= Bp1694) begin
      seg_lo = 2'd1;
    end else if (m < Bp1825) begin
      seg_lo = 2'd1; gap = 1'b1;
    end else if (m <= Bp2495) begin
      seg_lo = 2'd2;
    end else if (m < Bp2631) begin
      seg_lo = 2'd2; gap = 1'b1;
    end else begin
      seg_lo = 2'd3;
    end
  end

  function automatic logic [17:0] slp_f(input logic [1:0] k);
    case (k)
      2'd0:    slp_f = Slp0;
      2'd1:    slp_f = Slp1;
      2'd2:    slp_f = Slp2;
      default: slp_f = Slp3;
    endcase
  endfunction

  function automatic logic signed [29:0] ofs_f(input logic [1:0] k);
    case (k)
      2'd0:    ofs_f = Ofs0;
      2'd1:    ofs_f = Ofs1;
      2'd2:    ofs_f = Ofs2;
      default: ofs_f = Ofs3;
    endcase
  endfunction

  assign slp_a = slp_f(seg_lo);
  assign ofs_a = ofs_f(seg_lo);
  assign slp_b = slp_f(seg_lo + 2'd1);
  assign ofs_b = ofs_f(seg_lo + 2'd1);

  // Linearized value from the accumulator (offsets added here).
  logic signed [52:0] lin_sum;
  logic [36:0] lin_rnd;
  logic [19:0] lin_val;
  always_comb begin
    lin_sum = acc + 53'(ofs_a) + (gap ? 53'(ofs_b) : 53'sd0);
    lin_rnd = '0;
    if (!lin_sum[52]) begin
      lin_rnd = gap ? 37'((lin_sum + 53'sd65536) >>> 17)
                    : 37'((lin_sum + 53'sd32768) >>> 16);
    end
    if (below) lin_val = '0;
    else if (above) lin_val = 20'(m);
    else if (lin_rnd > 37'(DistMax)) lin_val = DistMax;
    else lin_val = lin_rnd[19:0];
  end

  // Filter update from the accumulator.
  logic [36:0] flt_rnd;
  logic [19:0] flt_val;
  always_comb begin
    flt_rnd = 37'((acc + 53'sd32768) >>> 16);
    if (filt_q[ch_q] == '0) flt_val = lin_q;
    else if (flt_rnd > 37'(DistMax)) flt_val = DistMax;
    else flt_val = flt_rnd[19:0];
  end

  // Error term.
  logic signed [21:0] ls, rs, err_d;
  logic signed [33:0] sum_raw;
  logic signed [31:0] sum_sat;
  always_comb begin
    ls = (filt_q[1] > 20'(cfg_q.side_wall_limit)) ? NoWallDist
                                                  : 22'($signed({1'b0, filt_q[1]}));
    rs = (filt_q[2] > 20'(cfg_q.side_wall_limit)) ? NoWallDist
                                                  : 22'($signed({1'b0, filt_q[2]}));
    err_d = 22'(cfg_q.centre_offset) + ls - rs;
    sum_raw = 34'(esum_q) + 34'(err_d) + 34'(perr_q);
    if (sum_raw > 34'sh7FFFFFFF) sum_sat = 32'sh7FFFFFFF;
    else if (sum_raw < -34'sh80000000) sum_sat = -32'sh80000000;
    else sum_sat = 32'(sum_raw);
  end

  // Steering from the accumulator.
  logic signed [52:0] pi_x, pi_sh;
  logic signed [23:0] steer_d;
  logic [2:0] cmd_d;
  always_comb begin
    pi_x = acc + 53'sd256;
    pi_sh = pi_x >>> 9;  // floor shift equals the model's rounding for both signs
    if (pi_sh > 53'(SteerMax)) steer_d = SteerMax;
    else if (pi_sh < 53'(SteerMin)) steer_d = SteerMin;
    else steer_d = 24'(pi_sh);
    if (filt_q[0] > 20'(cfg_q.front_clear_distance)) begin
      if (steer_d > -SteerOne && steer_d < SteerOne) cmd_d = CMD_FORWARD;
      else if (steer_d <= -SteerOne75) cmd_d = CMD_RIGHT_TURN;
      else if (steer_d >= SteerOne75) cmd_d = CMD_LEFT_TURN;
      else if (steer_d < -SteerOne) cmd_d = CMD_RIGHT_STRAFE;
      else if (steer_d > SteerOne) cmd_d = CMD_LEFT_STRAFE;
      else cmd_d = CMD_NONE;
    end else begin
      cmd_d = CMD_REVERSE;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    ch_d = ch_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LIN_A;
      ST_LIN_A: state_d = ST_LIN_B;
      ST_LIN_B: state_d = ST_LIN_R;
      ST_LIN_R: state_d = ST_FLT_A;
      ST_FLT_A: state_d = ST_FLT_B;
      ST_FLT_B: state_d = ST_FLT_R;
      ST_FLT_R: begin
        if (ch_q == 2'd2) begin
          state_d = ST_ERR; ch_d = 2'd0;
        end else begin
          state_d = ST_LIN_A; ch_d = ch_q + 2'd1;
        end
      end
      ST_ERR:   state_d = ST_PI_A;
      ST_PI_A:  state_d = ST_PI_B;
      ST_PI_B:  state_d = ST_PI_R;
      ST_PI_R:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // MAC operand selection.
  always_comb begin
    mac_en = 1'b0; mac_clr = 1'b0; mac_a = '0; mac_b = '0;
    case (state_q)
      ST_LIN_A: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = 33'(m); mac_b = $signed(slp_a);
      end
      ST_LIN_B: begin
        mac_en = gap; mac_a = 33'(m); mac_b = $signed(slp_b);
      end
      ST_FLT_A: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = 33'(filt_q[ch_q]);
        mac_b = 18'(cfg_q.filter_old_weight);
      end
      ST_FLT_B: begin
        mac_en = 1'b1; mac_a = 33'(lin_q); mac_b = 18'(cfg_q.filter_new_weight);
      end
      ST_PI_A: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = 33'(err_q);
        mac_b = 18'({cfg_q.prop_gain, 1'b0});
      end
      ST_PI_B: begin
        mac_en = 1'b1; mac_a = sum_q; mac_b = 18'(cfg_q.integral_gain);
      end
      default: ;
    endcase
  end

  rlf_mac u_mac (
    .clk_i (clk_i), .en_i (mac_en), .clr_i (mac_clr),
    .a_i (mac_a), .b_i (mac_b), .acc_o (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q <= '0;
      out_valid_q <= 1'b0;
      filt_q[0] <= '0; filt_q[1] <= '0; filt_q[2] <= '0;
      esum_q <= '0;
      perr_q <= '0;
      cfg_q.prop_gain <= 16'd256;
      cfg_q.integral_gain <= 16'd26;
      cfg_q.centre_offset <= '0;
      cfg_q.side_wall_limit <= 16'd2048;
      cfg_q.filter_new_weight <= 16'd32768;
      cfg_q.filter_old_weight <= 16'd32768;
      cfg_q.front_clear_distance <= 16'd1152;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_FLT_R) filt_q[ch_q] <= flt_val;
      if (state_q == ST_ERR) begin
        esum_q <= sum_sat;
        perr_q <= err_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN:            cfg_q.prop_gain <= cfg_data_i;
          REG_INTEGRAL_GAIN:        cfg_q.integral_gain <= cfg_data_i;
          REG_CENTRE_OFFSET:        cfg_q.centre_offset <= cfg_data_i;
          REG_SIDE_WALL_LIMIT:      cfg_q.side_wall_limit <= cfg_data_i;
          REG_FILTER_NEW_WEIGHT:    cfg_q.filter_new_weight <= cfg_data_i;
          REG_FILTER_OLD_WEIGHT:    cfg_q.filter_old_weight <= cfg_data_i;
          REG_FRONT_CLEAR_DISTANCE: cfg_q.front_clear_distance <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) raw_q <= in_data_i;
    if (state_q == ST_LIN_R) lin_q <= lin_val;
    if (state_q == ST_ERR) begin
      err_q <= err_d;
      sum_q <= 33'(sum_sat);
    end
    if (state_q == ST_PI_R) begin
      steer_q <= steer_d;
      cmd_q <= cmd_d;
    end
    if (out_load) begin
      out_q <= '{motion_command: cmd_q, steer_value: steer_q,
                 front_filtered: filt_q[0], left_filtered: filt_q[1],
                 right_filtered: filt_q[2]};
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `RLF_ASSERT_NXT(a_out_load, clk_i, rst_ni, state_q == ST_OUT && out_free, out_valid_o && state_q == ST_IDLE)
  `RLF_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == ST_LIN_A)
  `RLF_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `RLF_ASSERT_IMP(a_chan_range, clk_i, rst_ni, state_q != ST_IDLE, ch_q != 2'd3)
endmodule

// File: verif/tb_range_linearize_filter_pi_steer_top.sv
`timescale 1ns / 1ps

module tb_range_linearize_filter_pi_steer_top;
  import rlf_pkg::*;

  localparam int NumRandom = 950;
  localparam int Latency   = 22;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  range_linearize_filter_pi_steer_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration and the controller state.
  cfg_t         shadow_cfg;
  logic [19:0]  front_state, left_state, right_state;
  logic signed [31:0] err_sum_state;
  logic signed [21:0] prev_err_state;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        fail_count = 0;

  // Linearize one raw distance. Gaps between segments add both lines and
  // drop one more bit, which averages them.
  function automatic logic [19:0] linearize_distance(input logic [15:0] m);
    longint slope[4];
    longint offs[4];
    longint v;
    longint r;
    int     sh;
    slope[0] = Slp0; slope[1] = Slp1; slope[2] = Slp2; slope[3] = Slp3;
    offs[0] = Ofs0;  offs[1] = Ofs1;  offs[2] = Ofs2;  offs[3] = Ofs3;
    sh = 16;
    if (m < Bp184) return '0;
    if (m <= Bp828) v = m * slope[0] + offs[0];
    else if (m < Bp1017) begin
      v = m * slope[0] + offs[0] + m * slope[1] + offs[1];
      sh = 17;
    end else if (m <= Bp1694) v = m * slope[1] + offs[1];
    else if (m < Bp1825) begin
      v = m * slope[1] + offs[1] + m * slope[2] + offs[2];
      sh = 17;
    end else if (m <= Bp2495) v = m * slope[2] + offs[2];
    else if (m < Bp2631) begin
      v = m * slope[2] + offs[2] + m * slope[3] + offs[3];
      sh = 17;
    end else if (m <= Bp3125) v = m * slope[3] + offs[3];
    else return {4'd0, m};
    if (v < 0) v = 0;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    return (r > longint'(DistMax)) ? DistMax : r[19:0];
  endfunction

  function automatic logic [19:0] smooth(input logic [19:0] st, input logic [19:0] x);
    longint a;
    if (st == '0) return x;
    a = (longint'(st) * shadow_cfg.filter_old_weight
         + longint'(x) * shadow_cfg.filter_new_weight + 32768) >>> 16;
    return (a > longint'(DistMax)) ? DistMax : a[19:0];
  endfunction

  task automatic predict_steering(input in_item_t it);
    out_item_t res;
    longint ls, rs, e, s, acc, x, steer;
    longint one, one75;
    one = longint'(SteerOne);
    one75 = longint'(SteerOne75);
    front_state = smooth(front_state, linearize_distance(it.raw_front_distance));
    left_state  = smooth(left_state, linearize_distance(it.raw_left_distance));
    right_state = smooth(right_state, linearize_distance(it.raw_right_distance));
    // A side with no wall in range counts as 3.5 cm for the controller only.
    ls = (left_state > shadow_cfg.side_wall_limit) ? longint'(NoWallDist)
                                                   : longint'(left_state);
    rs = (right_state > shadow_cfg.side_wall_limit) ? longint'(NoWallDist)
                                                    : longint'(right_state);
    e = longint'(shadow_cfg.centre_offset) + ls - rs;
    s = longint'(err_sum_state) + e + longint'(prev_err_state);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    err_sum_state = s[31:0];
    prev_err_state = e[21:0];
    acc = 2 * longint'(shadow_cfg.prop_gain) * e + longint'(shadow_cfg.integral_gain) * s;
    x = acc + 256;
    if (x >= 0) steer = x >>> 9;
    else steer = -((-x + 511) >>> 9);
    if (steer > 8388607) steer = 8388607;
    if (steer < -8388608) steer = -8388608;
    if (front_state > shadow_cfg.front_clear_distance) begin
      if (steer > -one && steer < one) res.motion_command = CMD_FORWARD;
      else if (steer <= -one75) res.motion_command = CMD_RIGHT_TURN;
      else if (steer >= one75) res.motion_command = CMD_LEFT_TURN;
      else if (steer < -one) res.motion_command = CMD_RIGHT_STRAFE;
      else if (steer > one) res.motion_command = CMD_LEFT_STRAFE;
      else res.motion_command = CMD_NONE;
    end else begin
      res.motion_command = CMD_REVERSE;
    end
    res.steer_value = steer[23:0];
    res.front_filtered = front_state;
    res.left_filtered = left_state;
    res.right_filtered = right_state;
    expected_results = {expected_results, res};
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 4);
  endfunction

  // Acceptance as seen at the last rising edge, so the driver never races it.
  logic in_stall_o_q;
  always @(posedge clk_i) begin
    in_stall_o_q <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) predict_steering(in_data_i);
  end

  // Driver: one item at a time from the pending queue, with random gaps.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o_q) begin
        in_valid_i <= 1'b0;
        send_gap = pick_gap();
      end else if (!in_valid_i) begin
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver stall pattern.
  int stall_left = 0;
  logic stall_free = 1'b0;
  always @(negedge clk_i) begin
    if (stall_free) out_stall_i <= 1'b0;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  // Monitor: every taken result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.motion_command !== want.motion_command) begin
          $error("motion_command expected %0d got %0d", want.motion_command,
                 out_data_o.motion_command);
          fail_count++;
        end
        if (out_data_o.steer_value !== want.steer_value) begin
          $error("steer_value expected %0d got %0d", want.steer_value,
                 out_data_o.steer_value);
          fail_count++;
        end
        if (out_data_o.front_filtered !== want.front_filtered) begin
          $error("front_filtered expected %0d got %0d", want.front_filtered,
                 out_data_o.front_filtered);
          fail_count++;
        end
        if (out_data_o.left_filtered !== want.left_filtered) begin
          $error("left_filtered expected %0d got %0d", want.left_filtered,
                 out_data_o.left_filtered);
          fail_count++;
        end
        if (out_data_o.right_filtered !== want.right_filtered) begin
          $error("right_filtered expected %0d got %0d", want.right_filtered,
                 out_data_o.right_filtered);
          fail_count++;
        end
      end
    end
  end

  // Waits until the driver has sent everything and every result has come.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_PROP_GAIN:            shadow_cfg.prop_gain = val;
      REG_INTEGRAL_GAIN:        shadow_cfg.integral_gain = val;
      REG_CENTRE_OFFSET:        shadow_cfg.centre_offset = val;
      REG_SIDE_WALL_LIMIT:      shadow_cfg.side_wall_limit = val;
      REG_FILTER_NEW_WEIGHT:    shadow_cfg.filter_new_weight = val;
      REG_FILTER_OLD_WEIGHT:    shadow_cfg.filter_old_weight = val;
      REG_FRONT_CLEAR_DISTANCE: shadow_cfg.front_clear_distance = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_item(input logic [15:0] f, input logic [15:0] l, input logic [15:0] r);
    in_item_t it;
    it.raw_front_distance = f;
    it.raw_left_distance = l;
    it.raw_right_distance = r;
    pending_items = {pending_items, it};
  endtask

  // Random distance: mostly inside the mapped range, often near a breakpoint.
  function automatic logic [15:0] rand_distance();
    logic [16:0] bps[8];
    int sel;
    bps = '{Bp184, Bp828, Bp1017, Bp1694, Bp1825, Bp2495, Bp2631, Bp3125};
    sel = $urandom_range(0, 9);
    if (sel < 3) return 16'(bps[$urandom_range(0, 7)] + $urandom_range(0, 4) - 2);
    if (sel < 8) return 16'($urandom_range(0, 9000));
    return 16'($urandom());
  endfunction

  task automatic random_phase(input int count);
    repeat (count) add_item(rand_distance(), rand_distance(), rand_distance());
    drain();
  endtask

  initial begin
    logic [16:0] bps[8];
    bps = '{Bp184, Bp828, Bp1017, Bp1694, Bp1825, Bp2495, Bp2631, Bp3125};
    shadow_cfg = '{prop_gain: 16'd256, integral_gain: 16'd26, centre_offset: 16'sd0,
                   side_wall_limit: 16'd2048, filter_new_weight: 16'd32768,
                   filter_old_weight: 16'd32768, front_clear_distance: 16'd1152};
    front_state = '0; left_state = '0; right_state = '0;
    err_sum_state = '0; prev_err_state = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items: field extremes, every breakpoint and its neighbors,
    // an empty filter, front blocked, and side walls out of range.
    add_item(16'd0, 16'd0, 16'd0);
    add_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
    foreach (bps[i]) begin
      add_item(16'(bps[i]), 16'(bps[i] + 17'd1), 16'(bps[i] - 17'd1));
      add_item(16'(bps[i] + 17'd1), 16'(bps[i]), 16'(bps[i]));
    end
    add_item(16'd300, 16'd5000, 16'd1000);
    add_item(16'd9000, 16'd1000, 16'd5000);
    add_item(16'd9000, 16'd600, 16'd600);
    add_item(16'h5555, 16'hAAAA, 16'h5555);
    add_item(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    random_phase(150);

    // The sender holds off here until every expected result has arrived.
    random_phase(100);

    // Extremes of every register; new + old above one saturates the filter.
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    write_reg(REG_INTEGRAL_GAIN, 16'hFFFF);
    write_reg(REG_CENTRE_OFFSET, 16'h7FFF);
    write_reg(REG_SIDE_WALL_LIMIT, 16'hFFFF);
    write_reg(REG_FILTER_NEW_WEIGHT, 16'hFFFF);
    write_reg(REG_FILTER_OLD_WEIGHT, 16'hFFFF);
    write_reg(REG_FRONT_CLEAR_DISTANCE, 16'hFFFF);
    random_phase(120);

    write_reg(REG_PROP_GAIN, 16'd0);
    write_reg(REG_INTEGRAL_GAIN, 16'd0);
    write_reg(REG_CENTRE_OFFSET, 16'h8000);
    write_reg(REG_SIDE_WALL_LIMIT, 16'd0);
    write_reg(REG_FILTER_NEW_WEIGHT, 16'd0);
    write_reg(REG_FILTER_OLD_WEIGHT, 16'd0);
    write_reg(REG_FRONT_CLEAR_DISTANCE, 16'd0);
    random_phase(120);

    // Small gains keep the steering inside the forward dead band, so only forward and reverse show up.
    write_reg(REG_PROP_GAIN, 16'd1);
    write_reg(REG_INTEGRAL_GAIN, 16'd0);
    write_reg(REG_CENTRE_OFFSET, 16'd0);
    write_reg(REG_SIDE_WALL_LIMIT, 16'd4000);
    write_reg(REG_FILTER_NEW_WEIGHT, 16'd65535);
    write_reg(REG_FILTER_OLD_WEIGHT, 16'd0);
    write_reg(REG_FRONT_CLEAR_DISTANCE, 16'd500);
    random_phase(120);

    // Three random settings, with the receiver free of stalls in the first and third stretch.
    repeat (3) begin
      write_reg(REG_PROP_GAIN, 16'($urandom()));
      write_reg(REG_INTEGRAL_GAIN, 16'($urandom()));
      write_reg(REG_CENTRE_OFFSET, 16'($urandom()));
      write_reg(REG_SIDE_WALL_LIMIT, 16'($urandom()));
      write_reg(REG_FILTER_NEW_WEIGHT, 16'($urandom()));
      write_reg(REG_FILTER_OLD_WEIGHT, 16'($urandom()));
      write_reg(REG_FRONT_CLEAR_DISTANCE, 16'($urandom()));
      stall_free = ~stall_free;
      random_phase(100);
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Slowest correct run: ~1000 items, each with its longest gap, processing
  // and stall, at 10 ns a clock; the limit is several times that.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
